@@ rtl/lss_pkg.sv @@
// lss_pkg: shared codes and the result record of the lifo stack with search
// no dependencies; imported by lss_ctrl and lifo_stack_with_search_top
package lss_pkg;

    // fixed field widths of the request and result channels
    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_PUSH     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP      = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CONTAINS = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data_out;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } res_t;

endpackage

@@ rtl/lss_store.sv @@
// lss_store: element memory, one write port and one read port with registered data
// no package dependencies
module lss_store #(
    parameter int DATA_WIDTH  = 32,
    parameter int STACK_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]          wdata,
    input  logic                           re,
    input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]          rdata
);

    logic [DATA_WIDTH-1:0] mem_reg [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lss_ctrl.sv @@
// lss_ctrl: request sequencer, fill counter and the shared equality compare
// depends on lss_pkg; drives the port of lss_store
module lss_ctrl #(
    parameter int DATA_WIDTH  = 32,
    parameter int STACK_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [lss_pkg::ACTION_W-1:0]    req_action,
    input  logic [lss_pkg::VALUE_W-1:0]     req_value,
    output logic                            res_valid,
    input  logic                            res_ready,
    output lss_pkg::res_t                   res,
    output logic                            mem_we,
    output logic [$clog2(STACK_DEPTH)-1:0]  mem_waddr,
    output logic [DATA_WIDTH-1:0]           mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(STACK_DEPTH)-1:0]  mem_raddr,
    input  logic [DATA_WIDTH-1:0]           mem_rdata
);

    import lss_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            state_reg,  state_next;
    logic [CW-1:0]         count_reg,  count_next;
    logic [AW-1:0]         idx_reg,    idx_next;
    logic [ACTION_W-1:0]   act_reg,    act_next;
    logic [DATA_WIDTH-1:0] key_reg,    key_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_WIDTH-1:0] data_reg,   data_next;
    logic                  found_reg,  found_next;

    logic [DATA_WIDTH-1:0] value_dw;
    logic [CW-1:0]         cnt_m1;
    logic                  match;

    assign value_dw = DATA_WIDTH'(req_value);
    assign cnt_m1   = count_reg - CW'(1);
    // the one comparator, reused for every entry of a scan
    assign match    = (mem_rdata == key_reg);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_wdata   = value_dw;
        mem_re      = 1'b0;
        mem_raddr   = idx_reg;

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    act_next    = req_action;
                    key_next    = value_dw;
                    status_next = ST_DONE;
                    data_next   = '0;
                    found_next  = 1'b0;
                    state_next  = S_DONE;
                    case (req_action)
                        ACT_PUSH: begin
                            if (count_reg == FULL_CNT) begin
                                status_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_POP, ACT_PEEK: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = cnt_m1[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                        ACT_CONTAINS: begin
                            if (count_reg != '0) begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                idx_next   = AW'(1);
                                state_next = (count_reg == CW'(1)) ? S_DRAIN : S_SCAN;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                data_next = mem_rdata;
                if (act_reg == ACT_POP) begin
                    count_next = cnt_m1;
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                // read the next entry while comparing the one read last cycle
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                found_next = found_reg | match;
                idx_next   = idx_reg + AW'(1);
                if (idx_reg == cnt_m1[AW-1:0]) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                found_next = found_reg | match;
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        act_reg    <= act_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
    end

    assign res.status   = status_reg;
    assign res.data_out = VALUE_W'(data_reg);
    assign res.found    = found_reg;
    assign res.count    = COUNT_W'(count_reg);

`ifndef ASSERT_OFF
    // a push on a full store leaves the count alone and reports full
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req_ready && req_action == ACT_PUSH && count_reg == FULL_CNT)
        |=> ($stable(count_reg) && status_reg == ST_FULL))
        else $error("push on full store changed count or missed full status");

    // writes only land below the fill depth
    a_write_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (count_reg < FULL_CNT))
        else $error("memory write with store full");

    // a scan never reads past the newest element
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (CW'(idx_reg) <= cnt_m1))
        else $error("scan index beyond fill count");

    // a pop removes exactly one element
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && act_reg == ACT_POP)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not decrement count by one");

    // count never exceeds the depth, across any request
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> (count_reg <= FULL_CNT))
        else $error("fill count exceeded depth");
`endif

endmodule

@@ rtl/lifo_stack_with_search_top.sv @@
// lifo_stack_with_search_top: stream ports and result register of the lifo stack
// depends on lss_pkg, lss_store and lss_ctrl
//
// usage:
//   requests enter on the s_axis channel: tuser carries the action (push, pop,
//   peek, contains) and tdata the value to push or to search for
//   each request yields exactly one result on the m_axis channel with status,
//   popped or peeked element, found flag and the element count afterwards
// steps from acceptance to result valid:
//   push, or any request that finds the store full or empty: straight to the done state
//   pop and peek: one memory read with registered data
//   contains on n stored elements: the single comparator walks
//   the memory one entry per cycle through its one read port
//   s_axis_tready is high only while the sequencer is idle, so a new request
//   is taken once the previous one has moved into the result register
// stall: a finished result waits in the result register while m_axis_tready
//   is low; one more request can be worked on meanwhile, then the sequencer
//   holds its result until the register frees up
// reset: aresetn low clears the fill count and both valid flags; the element
//   memory needs no clearing, only entries below the count are ever read
module lifo_stack_with_search_top #(
    parameter int DATA_WIDTH  = 32,
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] data_out, [32] found, [39:33] count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    import lss_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    // memory port between sequencer and store
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // sequencer result hand-off
    logic res_valid;
    logic res_ready;
    res_t res;

    // output register
    logic m_valid_reg, m_valid_next;
    res_t m_res_reg;

    lss_store #(
        .DATA_WIDTH  (DATA_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lss_ctrl #(
        .DATA_WIDTH  (DATA_WIDTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_action (s_axis_tuser),
        .req_value  (s_axis_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // the result register takes a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload only moves on a hand-off
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_res_reg.count, m_res_reg.found, m_res_reg.data_out};
    assign m_axis_tuser  = m_res_reg.status;

endmodule
